### rtl/core/lgt_pkg.sv
package lgt_pkg;

    localparam int MAX_WIDTH     = 64;
    localparam int MAX_HEIGHT    = 4096;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int GW_W          = 7;
    localparam int GH_W          = 13;
    localparam int IDX_W         = 12;
    localparam int CFG_DATA_W    = 13;
    localparam int LANES         = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PUSH_W        = $clog2(LANES + 1);
    localparam int SUM_W         = 4;
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_GRID_WIDTH  = 1'b0;
    localparam t_cfg_index CFG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]     row_index;
        logic [MAX_WIDTH-1:0] bits;
        logic                 last;
    } t_result;

endpackage

### rtl/core/lgt_lane.sv
module lgt_lane import lgt_pkg::*; (
    input  logic [MAX_WIDTH-1:0] i_above,
    input  logic [MAX_WIDTH-1:0] i_cur,
    input  logic [MAX_WIDTH-1:0] i_below,
    input  logic [COL_W-1:0]     i_w_last,
    input  logic [MAX_WIDTH-1:0] i_mask,
    output logic [MAX_WIDTH-1:0] o_next
);

    logic a_wrap;
    logic c_wrap;
    logic b_wrap;

    // cell at the last active column, seen by column 0
    assign a_wrap = i_above[i_w_last];
    assign c_wrap = i_cur[i_w_last];
    assign b_wrap = i_below[i_w_last];

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_cell
        logic             a_l, a_r, c_l, c_r, b_l, b_r;
        logic             at_last;
        logic [SUM_W-1:0] n;

        assign at_last = (i_w_last == COL_W'(c));

        if (c == 0) begin : g_left_wrap
            assign a_l = a_wrap;
            assign c_l = c_wrap;
            assign b_l = b_wrap;
        end else begin : g_left
            assign a_l = i_above[c-1];
            assign c_l = i_cur[c-1];
            assign b_l = i_below[c-1];
        end

        if (c == MAX_WIDTH - 1) begin : g_right_edge
            assign a_r = i_above[0];
            assign c_r = i_cur[0];
            assign b_r = i_below[0];
        end else begin : g_right
            assign a_r = at_last ? i_above[0] : i_above[c+1];
            assign c_r = at_last ? i_cur[0]   : i_cur[c+1];
            assign b_r = at_last ? i_below[0] : i_below[c+1];
        end

        assign n = SUM_W'(a_l) + SUM_W'(i_above[c]) + SUM_W'(a_r)
                 + SUM_W'(c_l) + SUM_W'(c_r)
                 + SUM_W'(b_l) + SUM_W'(i_below[c]) + SUM_W'(b_r);

        assign o_next[c] = i_mask[c] & ((n == SUM_W'(BIRTH_COUNT))
                         | ((n == SUM_W'(SURVIVE_COUNT)) & i_cur[c]));
    end

endmodule

### rtl/core/lgt_queue.sv
module lgt_queue import lgt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PUSH_W-1:0]   i_push_cnt,
    input  t_result [LANES-1:0] i_entries,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_stall,
    output t_result             o_head
);

    t_result              r_slot [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count,  n_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= Q_CNT_W'(QUEUE_DEPTH - LANES));
    assign o_head  = r_slot[r_rd_ptr];
    assign pop     = o_valid & ~i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop);
        n_count  = r_count + Q_CNT_W'(i_push_cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // each slot takes the lane result at its distance from the write pointer
    for (genvar s = 0; s < QUEUE_DEPTH; s++) begin : g_slot
        logic [Q_PTR_W-1:0] offset;
        assign offset = Q_PTR_W'(s) - r_wr_ptr;
        always_ff @(posedge i_clk) begin
            if (PUSH_W'(offset) < i_push_cnt) begin
                r_slot[s] <= i_entries[offset];
            end
        end
    end

endmodule

### rtl/core/life_generation_toroidal.sv
// channel | direction | handshake            | payload
// input   | in        | i_valid / o_stall    | i_row_bits
// output  | out       | o_valid / i_stall    | o_row_index, o_next_row_bits,
//         |           |                      | o_last_of_generation
// config  | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// one row accepted per cycle while o_stall is low
// the last row of a generation yields three results, drained one per cycle
// while i_stall is low from a four-entry output queue
// o_stall rises while more than one result waits in the queue
// synchronous active-low reset clears the queue, row count and stored rows
module life_generation_toroidal import lgt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_index            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [MAX_WIDTH-1:0]  i_row_bits,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [IDX_W-1:0]      o_row_index,
    output logic [MAX_WIDTH-1:0]  o_next_row_bits,
    output logic                  o_last_of_generation
);

    logic [GW_W-1:0]      r_grid_width;
    logic [GH_W-1:0]      r_grid_height;
    logic [MAX_WIDTH-1:0] r_first, r_second, r_older, r_newer;
    logic [IDX_W-1:0]     r_row_count, n_row_count;

    logic [GW_W-1:0]      eff_width;
    logic [GH_W-1:0]      eff_height;
    logic [COL_W-1:0]     w_last;
    logic [MAX_WIDTH-1:0] mask;
    logic [MAX_WIDTH-1:0] row;
    logic                 accept;
    logic                 room;
    logic                 mid_row;
    logic                 wrap;
    logic [PUSH_W-1:0]    push_cnt;
    logic [MAX_WIDTH-1:0] lane_next [LANES];
    t_result [LANES-1:0]  entries;
    t_result              head;

    always_comb begin
        if (r_grid_width < GW_W'(3)) begin
            eff_width = GW_W'(3);
        end else if (r_grid_width > GW_W'(MAX_WIDTH)) begin
            eff_width = GW_W'(MAX_WIDTH);
        end else begin
            eff_width = r_grid_width;
        end
        if (r_grid_height < GH_W'(3)) begin
            eff_height = GH_W'(3);
        end else if (r_grid_height > GH_W'(MAX_HEIGHT)) begin
            eff_height = GH_W'(MAX_HEIGHT);
        end else begin
            eff_height = r_grid_height;
        end
    end

    assign w_last = COL_W'(eff_width - GW_W'(1));

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_mask
        assign mask[i] = (GW_W'(i) < eff_width);
    end

    assign row     = i_row_bits & mask;
    assign o_stall = ~room;
    assign accept  = i_valid & room;
    assign mid_row = (r_row_count >= IDX_W'(2));
    assign wrap    = mid_row
                   && ((GH_W'(r_row_count) + GH_W'(1)) >= eff_height);

    always_comb begin
        if (!accept) begin
            push_cnt = '0;
        end else if (wrap) begin
            push_cnt = PUSH_W'(LANES);
        end else if (mid_row) begin
            push_cnt = PUSH_W'(1);
        end else begin
            push_cnt = '0;
        end
        n_row_count = wrap ? '0 : r_row_count + IDX_W'(1);
    end

    lgt_lane u_lane_mid (
        .i_above (r_older),
        .i_cur   (r_newer),
        .i_below (row),
        .i_w_last(w_last),
        .i_mask  (mask),
        .o_next  (lane_next[0])
    );

    lgt_lane u_lane_last (
        .i_above (r_newer),
        .i_cur   (row),
        .i_below (r_first),
        .i_w_last(w_last),
        .i_mask  (mask),
        .o_next  (lane_next[1])
    );

    lgt_lane u_lane_zero (
        .i_above (row),
        .i_cur   (r_first),
        .i_below (r_second),
        .i_w_last(w_last),
        .i_mask  (mask),
        .o_next  (lane_next[2])
    );

    always_comb begin
        entries[0] = '{row_index: r_row_count - IDX_W'(1), bits: lane_next[0], last: 1'b0};
        entries[1] = '{row_index: r_row_count, bits: lane_next[1], last: 1'b0};
        entries[2] = '{row_index: '0, bits: lane_next[2], last: 1'b1};
    end

    lgt_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_cnt(push_cnt),
        .i_entries (entries),
        .o_room    (room),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_head    (head)
    );

    assign o_row_index          = head.row_index;
    assign o_next_row_bits      = head.bits;
    assign o_last_of_generation = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GW_W'(MAX_WIDTH);
            r_grid_height <= GH_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GW_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= '0;
            r_second    <= '0;
            r_older     <= '0;
            r_newer     <= '0;
            r_row_count <= '0;
        end else if (accept) begin
            if (r_row_count == '0) begin
                r_first <= row;
            end
            if (r_row_count == IDX_W'(1)) begin
                r_second <= row;
            end
            r_older     <= r_newer;
            r_newer     <= row;
            r_row_count <= n_row_count;
        end
    end

endmodule

### rtl/core/lgt_checker.sv
module lgt_checker import lgt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [IDX_W-1:0]      o_row_index,
    input logic [MAX_WIDTH-1:0]  o_next_row_bits,
    input logic                  o_last_of_generation
);

    // a reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // input back-pressure only comes from results waiting in the queue
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty queue");

    // generation closes on row zero
    a_last_is_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_generation |-> o_row_index == '0)
        else $error("last transaction not row zero");

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_row_index)
            && $stable(o_next_row_bits) && $stable(o_last_of_generation))
        else $error("stalled output transaction changed");

endmodule

bind life_generation_toroidal lgt_checker u_lgt_checker (.*);
